/* hdl/rpn_stack_evaluator_defines.svh */
// Assertion helpers shared by the RTL files.
// Every check runs on the rising edge of clk_i and is held off while rst_ni is low.
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

// Check a property on every clock edge.
`define RSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define RSE_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define RSE_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

  localparam int StackDepth = 32;
  localparam int DataW      = 32;
  localparam int SpW        = $clog2(StackDepth + 1);
  localparam int AddrW      = $clog2(StackDepth);
  localparam int CntW       = $clog2(DataW);
  localparam int SumW       = DataW + 1;
  localparam int OpW        = 3;
  localparam int OutW       = 32;
  localparam int DepthW     = 6;
  localparam int StatW      = 2;

  typedef enum logic [OpW-1:0] {
    OP_PUSH = 0,
    OP_ADD  = 1,
    OP_SUB  = 2,
    OP_MUL  = 3,
    OP_DIV  = 4
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 0,
    STAT_UNDER = 1,
    STAT_OVER  = 2,
    STAT_DIVZ  = 3
  } status_e;

  typedef logic signed [DataW-1:0] data_t;

  typedef struct packed {
    logic           start;
    logic [OpW-1:0] op;
    data_t          a;
    data_t          b;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    data_t result;
  } alu_rsp_t;

  // Keep the first error of an expression.
  function automatic status_e note_err(status_e cur, status_e code);
    return (cur == STAT_OK) ? code : cur;
  endfunction

endpackage

`default_nettype wire

/* hdl/rse_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rse_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/rse_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

module rse_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rse_pkg::alu_req_t req_i,
  output rse_pkg::alu_rsp_t rsp_o
);

  import rse_pkg::*;

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MUL  = 2'd1;
  localparam logic [1:0] A_DIV  = 2'd2;
  localparam logic [1:0] A_FIX  = 2'd3;

  logic [1:0]      state_q, state_d;
  data_t           acc_q, acc_d;
  data_t           quo_q, quo_d;
  data_t           dvs_q, dvs_d;
  data_t           res_q, res_d;
  logic            neg_q, neg_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [SumW-1:0] add_x, add_y, add_sum, rem_sh;
  logic            add_sub;
  data_t           a_abs, b_abs, mul_next;

  // One shared adder: add, subtract, multiply accumulate, divide trial subtract.
  assign add_sum  = add_x + (add_sub ? ~add_y : add_y) + SumW'(add_sub);
  assign rem_sh   = {acc_q, quo_q[DataW-1]};
  assign mul_next = quo_q[0] ? add_sum[DataW-1:0] : acc_q;
  assign a_abs    = req_i.a[DataW-1] ? (~req_i.a + DataW'(1)) : req_i.a;
  assign b_abs    = req_i.b[DataW-1] ? (~req_i.b + DataW'(1)) : req_i.b;

  always_comb begin
    unique case (state_q)
      A_MUL: begin
        add_x   = {1'b0, acc_q};
        add_y   = {1'b0, dvs_q};
        add_sub = 1'b0;
      end
      A_DIV: begin
        add_x   = rem_sh;
        add_y   = {1'b0, dvs_q};
        add_sub = 1'b1;
      end
      default: begin
        add_x   = {1'b0, req_i.a};
        add_y   = {1'b0, req_i.b};
        add_sub = (req_i.op == OP_SUB);
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    res_d   = res_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op) inside
            OP_ADD, OP_SUB: begin
              res_d  = add_sum[DataW-1:0];
              done_d = 1'b1;
            end
            OP_MUL: begin
              acc_d   = '0;
              dvs_d   = req_i.a;
              quo_d   = req_i.b;
              cnt_d   = CntW'(DataW - 1);
              state_d = A_MUL;
            end
            OP_DIV: begin
              acc_d   = '0;
              quo_d   = a_abs;
              dvs_d   = b_abs;
              neg_d   = req_i.a[DataW-1] ^ req_i.b[DataW-1];
              cnt_d   = CntW'(DataW - 1);
              state_d = A_DIV;
            end
            default: begin
              res_d  = '0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      A_MUL: begin
        // Shift-add: one multiplier bit per cycle, low word kept.
        acc_d = mul_next;
        dvs_d = {dvs_q[DataW-2:0], 1'b0};
        quo_d = {1'b0, quo_q[DataW-1:1]};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          res_d   = mul_next;
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      A_DIV: begin
        // Restoring divide on magnitudes: one quotient bit per cycle.
        if (!add_sum[DataW]) begin
          acc_d = add_sum[DataW-1:0];
          quo_d = {quo_q[DataW-2:0], 1'b1};
        end else begin
          acc_d = rem_sh[DataW-1:0];
          quo_d = {quo_q[DataW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = A_FIX;
        end
      end
      A_FIX: begin
        res_d   = neg_q ? (~quo_q + DataW'(1)) : quo_q;
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    res_q <= res_d;
    neg_q <= neg_d;
  end

  assign rsp_o = '{done: done_q, result: res_q};

endmodule

`default_nettype wire

/* hdl/rpn_stack_evaluator.sv */
// Channel  Dir  Handshake              Beat contents
// in       in   in_valid_i/in_ready_o   op_i, operand_i, end_of_expr_i
// out      out  out_valid_o/out_ready_i top_value_o, stack_depth_o, status_o
//
// A token is accepted only in idle; ready stays low until it has been worked through.
// Multiply and divide run on the shared ALU, which steps one bit per cycle over
// the data width.
// Reset is asynchronous, active low; the stack comes up empty, no clearing pass.
// A result beat sits in the output register; the next token is accepted while it
// waits, and only a second end-of-expression token stalls until it is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "rpn_stack_evaluator_defines.svh"

module rpn_stack_evaluator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rse_pkg::OpW-1:0]           op_i,
  input  logic signed [31:0]                operand_i,
  input  logic                              end_of_expr_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [rse_pkg::OutW-1:0]   top_value_o,
  output logic [rse_pkg::DepthW-1:0]        stack_depth_o,
  output logic [rse_pkg::StatW-1:0]         status_o
);

  import rse_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // ready for a token
  localparam logic [2:0] S_EXEC = 3'd1;  // check the stack, push or start a read
  localparam logic [2:0] S_READ = 3'd2;  // second operand arrives, start the ALU
  localparam logic [2:0] S_WAIT = 3'd3;  // wait for the ALU result
  localparam logic [2:0] S_FIN  = 3'd4;  // emit the result beat on end of expression

  logic [2:0]            state_q, state_d;
  logic [OpW-1:0]        op_q;
  data_t                 operand_q;
  logic                  last_q;
  logic [SpW-1:0]        sp_q, sp_d;
  data_t                 top_q, top_d;   // top of stack lives here, the rest in RAM
  status_e               err_q, err_d;

  logic                  out_valid_q, out_valid_d, out_load;
  logic signed [OutW-1:0] out_top_q;
  logic [DepthW-1:0]     out_depth_q;
  status_e               out_stat_q;

  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr, ram_raddr;
  data_t                 ram_wdata;
  logic [DataW-1:0]      ram_rdata;

  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;

  rse_ram #(
    .Width (DataW),
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rse_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  // The second entry sits one below the top register.
  assign ram_raddr  = AddrW'(sp_q - SpW'(2));

  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    top_d     = top_q;
    err_d     = err_q;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AddrW'(sp_q - SpW'(1));
    ram_wdata = top_q;
    alu_req   = '{start: 1'b0, op: op_q, a: ram_rdata, b: top_q};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FIN;
        case (op_q) inside
          OP_PUSH: begin
            if (sp_q >= SpW'(StackDepth)) begin
              // Full stack: drop the push.
              err_d = note_err(err_q, STAT_OVER);
            end else begin
              // Spill the old top into RAM, then take the operand as new top.
              ram_we = (sp_q != '0);
              top_d  = operand_q;
              sp_d   = sp_q + SpW'(1);
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (sp_q < SpW'(2)) begin
              err_d = note_err(err_q, STAT_UNDER);
            end else if (op_q == OP_DIV && top_q == '0) begin
              err_d = note_err(err_q, STAT_DIVZ);
            end else begin
              state_d = S_READ;
            end
          end
          default: ;  // unknown token: leave the stack alone
        endcase
      end
      S_READ: begin
        alu_req.start = 1'b1;
        state_d       = S_WAIT;
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          // Pop two, push one: the result replaces the second entry as top.
          top_d   = alu_rsp.result;
          sp_d    = sp_q - SpW'(1);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          sp_d     = '0;
          err_d    = STAT_OK;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      err_q       <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (in_valid_i && in_ready_o) begin
      op_q      <= op_i;
      operand_q <= DataW'(operand_i);
      last_q    <= end_of_expr_i;
    end
    if (out_load) begin
      out_top_q   <= (sp_q != '0) ? OutW'(top_q) : '0;
      out_depth_q <= DepthW'(sp_q);
      out_stat_q  <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign top_value_o   = out_top_q;
  assign stack_depth_o = out_depth_q;
  assign status_o      = out_stat_q;

  `RSE_ASSERT(a_sp_bound, sp_q <= SpW'(StackDepth), "stack pointer past the stack depth")
  `RSE_IMPLIES(a_alu_done_wait, alu_rsp.done, state_q == S_WAIT, "ALU result outside wait")
  `RSE_IMPLIES(a_out_from_fin, $rose(out_valid_q), $past(state_q == S_FIN && last_q),
    "result beat not caused by an end-of-expression token")
  `RSE_NEXT(a_pop_one, state_q == S_WAIT && alu_rsp.done, sp_q == $past(sp_q) - SpW'(1),
    "arithmetic token did not pop exactly one entry")
  `RSE_NEXT(a_err_sticky, err_q != STAT_OK && !(state_q == S_FIN && last_q),
    err_q == $past(err_q), "sticky error changed within an expression")

endmodule

`default_nettype wire

/* dv/rpn_stack_checker.sv */
`timescale 1ns / 1ps

module rpn_stack_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [rse_pkg::OpW-1:0]         op_i,
  input  logic signed [31:0]              operand_i,
  input  logic                            end_of_expr_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic signed [rse_pkg::OutW-1:0] top_value_i,
  input  logic [rse_pkg::DepthW-1:0]      stack_depth_i,
  input  logic [rse_pkg::StatW-1:0]       status_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import rse_pkg::*;

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic signed [OutW-1:0] top;
    logic [DepthW-1:0]      depth;
    status_e                status;
  } expr_result_t;

  data_t        operand_stack [StackDepth];
  int unsigned  stack_ptr;
  status_e      first_err;
  expr_result_t expr_results [$];
  int           fail_count;

  // Signed quotient truncated toward zero, worked on magnitudes so that the
  // most negative value over minus one wraps instead of trapping.
  function automatic data_t quotient_toward_zero(data_t num, data_t den);
    logic [DataW-1:0] mag_num;
    logic [DataW-1:0] mag_den;
    logic [DataW-1:0] quo;
    mag_num = num[DataW-1] ? -num : num;
    mag_den = den[DataW-1] ? -den : den;
    quo     = mag_num / mag_den;
    if (num[DataW-1] != den[DataW-1]) quo = -quo;
    return data_t'(quo);
  endfunction

  task automatic keep_first_error(status_e code);
    if (first_err == STAT_OK) first_err = code;
  endtask

  // Apply one token to the shadow stack; queue a result on end of expression.
  task automatic evaluate_token(logic [OpW-1:0] op, data_t opnd, logic last);
    data_t        tos;
    data_t        nos;
    data_t        res;
    bit           done;
    expr_result_t beat;
    res  = '0;
    done = 1'b1;
    if (op == OP_PUSH) begin
      if (stack_ptr >= StackDepth) begin
        keep_first_error(STAT_OVER);
      end else begin
        operand_stack[stack_ptr] = opnd;
        stack_ptr++;
      end
    end else if (op <= OP_DIV) begin
      if (stack_ptr < 2) begin
        keep_first_error(STAT_UNDER);
      end else begin
        tos = operand_stack[stack_ptr-1];
        nos = operand_stack[stack_ptr-2];
        case (op)
          OP_ADD: res = nos + tos;
          OP_SUB: res = nos - tos;
          OP_MUL: res = nos * tos;
          default: begin
            if (tos == 0) begin
              keep_first_error(STAT_DIVZ);
              done = 1'b0;
            end else begin
              res = quotient_toward_zero(nos, tos);
            end
          end
        endcase
        if (done) begin
          stack_ptr--;
          operand_stack[stack_ptr-1] = res;
        end
      end
    end
    if (last) begin
      beat.top    = (stack_ptr > 0) ? operand_stack[stack_ptr-1] : '0;
      beat.depth  = stack_ptr[DepthW-1:0];
      beat.status = first_err;
      expr_results.push_back(beat);
      stack_ptr = 0;
      first_err = STAT_OK;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    expr_result_t want;
    if (!rst_ni) begin
      stack_ptr = 0;
      first_err = STAT_OK;
      expr_results.delete();
      fail_count = 0;
    end else begin
      // Check the result beat first so a token taken in the same cycle
      // cannot hide a beat that arrived early.
      if (out_valid_i && out_ready_i) begin
        if (expr_results.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit)
            $display("%0t: unexpected result beat: top %0d depth %0d status %0d",
                     $realtime, top_value_i, stack_depth_i, status_i);
        end else begin
          want = expr_results.pop_front();
          if (top_value_i !== want.top || stack_depth_i !== want.depth ||
              status_i !== want.status) begin
            fail_count++;
            if (fail_count <= ReportLimit)
              $display("%0t: mismatch: want top %0d depth %0d status %0d, got %0d %0d %0d",
                       $realtime, want.top, want.depth, want.status,
                       top_value_i, stack_depth_i, status_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) evaluate_token(op_i, operand_i, end_of_expr_i);
    end
    fail_count_o = fail_count;
    pending_o    = expr_results.size();
  end

endmodule

/* dv/tb_rpn_stack_evaluator.sv */
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator;
  import rse_pkg::*;

  localparam int TokenTarget  = 1200;
  localparam int CycleLimit   = 500000;
  localparam int DrainCycles  = 80;
  localparam int DrainEvery   = 40;

  typedef struct {
    logic [OpW-1:0] op;
    data_t          val;
  } token_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic [OpW-1:0]         tok_op      = OP_PUSH;
  logic signed [31:0]     tok_operand = '0;
  logic                   tok_last    = 1'b0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic signed [OutW-1:0] top_value;
  logic [DepthW-1:0]      stack_depth;
  logic [StatW-1:0]       status;

  int          fail_count;
  int          pending;
  int unsigned token_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle     = 1'b0;
  token_t      expr_q [$];

  // 8 ns clock: 4 ns high, 4 ns low.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rpn_stack_evaluator DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (tok_op),
    .operand_i     (tok_operand),
    .end_of_expr_i (tok_last),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .top_value_o   (top_value),
    .stack_depth_o (stack_depth),
    .status_o      (status)
  );

  rpn_stack_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .op_i          (tok_op),
    .operand_i     (tok_operand),
    .end_of_expr_i (tok_last),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .top_value_i   (top_value),
    .stack_depth_i (stack_depth),
    .status_i      (status),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Result side: drop ready in about 30% of cycles, except in the no-idle stretch.
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 30);
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_rpn_stack_evaluator NOT OK");
      $finish;
    end
  end

  // Bias operands toward the edges: zero feeds divide-by-zero, the extremes
  // feed wraparound, small values keep quotients interesting.
  function automatic data_t pick_operand();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 1;
      2:       return -1;
      3:       return {1'b0, {(DataW-1){1'b1}}};
      4:       return {1'b1, {(DataW-1){1'b0}}};
      5, 6:    return data_t'($urandom_range(200)) - 100;
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic add_token(logic [OpW-1:0] op, data_t val);
    token_t tok;
    tok.op  = op;
    tok.val = val;
    expr_q.push_back(tok);
  endtask

  // Build a well-formed expression with the given number of pushes. A stacked
  // one pushes everything first, so the stack runs as deep as it goes.
  task automatic build_expr(int pushes, bit stacked);
    int depth;
    int left;
    expr_q.delete();
    depth = 0;
    left  = pushes;
    while (left > 0 || depth > 1) begin
      if (left > 0 && (stacked || depth < 2 || $urandom_range(1) == 0)) begin
        add_token(OP_PUSH, pick_operand());
        depth++;
        left--;
      end else begin
        add_token(OpW'($urandom_range(OP_ADD, OP_DIV)), data_t'($urandom));
        depth--;
      end
    end
  endtask

  // Present one beat at a falling edge and hold it until taken. Valid stays
  // high on exit so a back-to-back beat never sees it toggle.
  task automatic send_token(logic [OpW-1:0] op, data_t val, logic last);
    int gap;
    if (!no_idle && $urandom_range(99) < 30) begin
      gap = $urandom_range(1, 8);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    tok_op      = op;
    tok_operand = val;
    tok_last    = last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op <= OP_DIV || last) token_count++;
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_q.size(); i++)
      send_token(expr_q[i].op, expr_q[i].val, i == expr_q.size() - 1);
  endtask

  // Hold off the sender until every queued result has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int sel;
    int keep;
    int expr_count;
    expr_count = 0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: largest plus one wraps to the most negative value.
    expr_q.delete();
    add_token(OP_PUSH, {1'b0, {(DataW-1){1'b1}}});
    add_token(OP_PUSH, 1);
    add_token(OP_ADD, '0);
    send_expr();

    // Most negative over minus one wraps back to itself.
    expr_q.delete();
    add_token(OP_PUSH, {1'b1, {(DataW-1){1'b0}}});
    add_token(OP_PUSH, -1);
    add_token(OP_DIV, -1);
    send_expr();

    // (7 - 3) * -3 / 5: subtract order, multiply, truncation toward zero.
    expr_q.delete();
    add_token(OP_PUSH, 7);
    add_token(OP_PUSH, 3);
    add_token(OP_SUB, '1);
    add_token(OP_PUSH, -3);
    add_token(OP_MUL, '0);
    add_token(OP_PUSH, 5);
    add_token(OP_DIV, '0);
    send_expr();

    // Divide by zero leaves both entries in place.
    expr_q.delete();
    add_token(OP_PUSH, 5);
    add_token(OP_PUSH, 0);
    add_token(OP_DIV, '0);
    send_expr();

    // Arithmetic on an empty stack underflows.
    expr_q.delete();
    add_token(OP_ADD, '0);
    send_expr();

    // Underflow sticks even though a divide by zero follows.
    expr_q.delete();
    add_token(OP_PUSH, 1);
    add_token(OP_SUB, '0);
    add_token(OP_PUSH, 0);
    add_token(OP_DIV, '0);
    send_expr();

    // Unknown token kinds are ignored but still close an expression.
    expr_q.delete();
    add_token(3'd7, '1);
    send_expr();
    expr_q.delete();
    add_token(OP_PUSH, 9);
    add_token(3'd5, '0);
    add_token(3'd6, '1);
    send_expr();
    drain_results();

    // Fill the stack past its top so a push overflows, then fold it back.
    build_expr(StackDepth + 2, 1'b1);
    send_expr();

    // Random part: mostly well-formed expressions, some deep, some noise.
    while (token_count < TokenTarget) begin
      no_idle = (token_count >= 500 && token_count < 700);
      sel = $urandom_range(99);
      if (sel < 8) begin
        expr_q.delete();
        repeat ($urandom_range(1, 6)) add_token(OpW'($urandom_range(7)), data_t'($urandom));
      end else if (sel < 14) begin
        // Cut a good expression short: leaves extra entries on the stack.
        build_expr($urandom_range(2, 8), 1'b0);
        keep = $urandom_range(1, expr_q.size());
        while (expr_q.size() > keep) void'(expr_q.pop_back());
      end else if (sel < 19) begin
        build_expr($urandom_range(16, StackDepth + 2), 1'b1);
      end else begin
        build_expr($urandom_range(1, 8), 1'b0);
      end
      send_expr();
      expr_count++;
      if (expr_count % DrainEvery == 0) drain_results();
    end

    no_idle  = 1'b0;
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_rpn_stack_evaluator OK");
    end else begin
      $display("tb_rpn_stack_evaluator NOT OK");
    end
    $finish;
  end

endmodule
